// ----- sv/id3d_pkg.sv -----
package id3d_pkg;

    // magic bytes of a tag header
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_3 = 8'h33;

    // four-character frame ids (v2.3 / v2.4)
    localparam logic [31:0] ID_APIC = 32'h4150_4943;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_USLT = 32'h5553_4C54;

    // three-character frame ids (v2.2)
    localparam logic [23:0] ID2_TT2 = 24'h54_5432;
    localparam logic [23:0] ID2_TP1 = 24'h54_5031;
    localparam logic [23:0] ID2_TAL = 24'h54_414C;
    localparam logic [23:0] ID2_COM = 24'h43_4F4D;

    // frame kind codes
    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_APIC    = 4'd1;
    localparam logic [3:0] KIND_COMM    = 4'd2;
    localparam logic [3:0] KIND_TALB    = 4'd3;
    localparam logic [3:0] KIND_TIT2    = 4'd4;
    localparam logic [3:0] KIND_TPE1    = 4'd5;
    localparam logic [3:0] KIND_TYER    = 4'd6;
    localparam logic [3:0] KIND_TCON    = 4'd7;
    localparam logic [3:0] KIND_TRCK    = 4'd8;
    localparam logic [3:0] KIND_USLT    = 4'd9;

    // header geometry
    localparam logic [7:0] VER_SHORT      = 8'd2;
    localparam logic [7:0] VER_MIN        = 8'd2;
    localparam logic [7:0] VER_MAX        = 8'd4;
    localparam logic [3:0] HDR_LEN_LONG   = 4'd10;
    localparam logic [3:0] HDR_LEN_SHORT  = 4'd6;
    localparam logic [3:0] ID_LEN_LONG    = 4'd4;
    localparam logic [3:0] ID_LEN_SHORT   = 4'd3;
    localparam logic [3:0] TAG_HDR_VER    = 4'd3;
    localparam logic [3:0] TAG_HDR_SIZE0  = 4'd6;
    localparam logic [3:0] TAG_HDR_LAST   = 4'd9;
    localparam logic [27:0] SIZE_MAX      = 28'hFFF_FFFF;

    // configuration address decode
    localparam int unsigned PADDR_W      = 3;
    localparam logic        REG_MAX_TAG  = 1'b0;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_TAG   = 2'd1,
        EV_END   = 2'd2,
        EV_NOTAG = 2'd3
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [3:0]  frame_kind;
        logic [7:0]  data_byte;
        logic        frame_last;
        logic        tag_last;
        logic [7:0]  tag_version;
        logic [27:0] tag_size;
    } evt_t;

    function automatic logic [3:0] lookup_kind(input logic [31:0] id, input logic short_hdr);
        logic [3:0] k;
        k = KIND_UNKNOWN;
        if (short_hdr) begin
            case (id[23:0])
                ID2_TT2: k = KIND_TIT2;
                ID2_TP1: k = KIND_TPE1;
                ID2_TAL: k = KIND_TALB;
                ID2_COM: k = KIND_COMM;
                default: k = KIND_UNKNOWN;
            endcase
        end else begin
            case (id)
                ID_APIC: k = KIND_APIC;
                ID_COMM: k = KIND_COMM;
                ID_TALB: k = KIND_TALB;
                ID_TIT2: k = KIND_TIT2;
                ID_TPE1: k = KIND_TPE1;
                ID_TYER: k = KIND_TYER;
                ID_TCON: k = KIND_TCON;
                ID_TRCK: k = KIND_TRCK;
                ID_USLT: k = KIND_USLT;
                default: k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

endpackage

// ----- sv/id3d_front.sv -----
module id3d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           stream_byte,
    input  logic                 stream_start,
    input  logic [27:0]          max_tag_size,
    output logic                 evt_push,
    output id3d_pkg::evt_t       evt_data
);
    import id3d_pkg::*;

    typedef enum logic [5:0] {
        PH_SEEK     = 6'b000001,
        PH_TAGHDR   = 6'b000010,
        PH_FRAMEHDR = 6'b000100,
        PH_PAYLOAD  = 6'b001000,
        PH_SKIP     = 6'b010000,
        PH_DONE     = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [3:0]  hc_reg, hc_next, cur_hc, hc_inc;
    logic [31:0] id_reg, id_next, id_new;
    logic [31:0] size_reg, size_next, size_new;
    logic [7:0]  ver_reg, ver_next;
    logic [27:0] tag_rem_reg, tag_rem_next, tag_dec;
    logic [27:0] frame_rem_reg, frame_rem_next, frame_dec, fs;
    logic [3:0]  kind_reg, kind_next;
    logic [27:0] tag_size_calc;
    logic        short_hdr, room;
    logic [3:0]  hdr_len, id_len;
    evt_t        evt;

    // a start mark restarts the walk on this very byte
    assign cur_phase = stream_start ? PH_SEEK : phase_reg;
    assign cur_hc    = stream_start ? 4'd0 : hc_reg;
    assign hc_inc    = cur_hc + 4'd1;

    assign tag_dec   = (tag_rem_reg != 28'd0) ? tag_rem_reg - 28'd1 : 28'd0;
    assign frame_dec = (frame_rem_reg != 28'd0) ? frame_rem_reg - 28'd1 : 28'd0;

    assign short_hdr = (ver_reg == VER_SHORT);
    assign hdr_len   = short_hdr ? HDR_LEN_SHORT : HDR_LEN_LONG;
    assign id_len    = short_hdr ? ID_LEN_SHORT : ID_LEN_LONG;
    assign room      = short_hdr ? (tag_rem_reg >= 28'd6) : (tag_rem_reg > 28'd10);

    // synchsafe size: seven bits per byte
    assign tag_size_calc = {size_reg[20:0], stream_byte[6:0]};

    // frame header field capture, fields restart on the first header byte
    always_comb begin
        id_new   = (cur_hc == 4'd0) ? 32'd0 : id_reg;
        size_new = (cur_hc == 4'd0) ? 32'd0 : size_reg;
        if (cur_hc < id_len) begin
            id_new = {id_new[23:0], stream_byte};
        end else if (cur_hc < {id_len[2:0], 1'b0}) begin
            size_new = {size_new[23:0], stream_byte};
        end
    end

    // clamp frame size to what is left of the tag
    assign fs = (size_new > {4'd0, tag_dec}) ? tag_dec : size_new[27:0];

    // parser step
    always_comb begin
        phase_next     = phase_reg;
        hc_next        = hc_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        ver_next       = ver_reg;
        tag_rem_next   = tag_rem_reg;
        frame_rem_next = frame_rem_reg;
        kind_next      = kind_reg;
        evt            = '0;
        evt_push       = 1'b0;
        if (in_accept) begin
            phase_next = cur_phase;
            hc_next    = cur_hc;
            case (cur_phase)
                PH_SEEK: begin
                    if (stream_byte == CH_I) begin
                        phase_next = PH_TAGHDR;
                        hc_next    = 4'd1;
                        size_next  = 32'd0;
                    end else if (stream_byte != 8'd0) begin
                        phase_next    = PH_DONE;
                        evt_push      = 1'b1;
                        evt.event_res = EV_NOTAG;
                    end
                end
                PH_TAGHDR: begin
                    if ((cur_hc == 4'd1 && stream_byte != CH_D) ||
                        (cur_hc == 4'd2 && stream_byte != CH_3)) begin
                        phase_next    = PH_DONE;
                        evt_push      = 1'b1;
                        evt.event_res = EV_NOTAG;
                    end else begin
                        if (cur_hc == TAG_HDR_VER) begin
                            ver_next = stream_byte;
                        end
                        if (cur_hc >= TAG_HDR_SIZE0) begin
                            size_next = {4'd0, tag_size_calc};
                        end
                        if (cur_hc < TAG_HDR_LAST) begin
                            hc_next = hc_inc;
                        end else begin
                            hc_next      = 4'd0;
                            tag_rem_next = tag_size_calc;
                            if (tag_size_calc == 28'd0) begin
                                phase_next = PH_SEEK;
                            end else if (tag_size_calc > max_tag_size ||
                                         ver_reg < VER_MIN || ver_reg > VER_MAX) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_FRAMEHDR;
                            end
                            evt_push        = 1'b1;
                            evt.event_res   = EV_TAG;
                            evt.tag_last    = (tag_size_calc == 28'd0);
                            evt.tag_version = ver_reg;
                            evt.tag_size    = tag_size_calc;
                        end
                    end
                end
                PH_FRAMEHDR: begin
                    tag_rem_next = tag_dec;
                    if (cur_hc == 4'd0 && (!room || stream_byte == 8'd0)) begin
                        // padding or no room for a frame: skip the rest
                        phase_next = PH_SKIP;
                        if (tag_dec == 28'd0) begin
                            phase_next    = PH_SEEK;
                            evt_push      = 1'b1;
                            evt.event_res = EV_END;
                            evt.tag_last  = 1'b1;
                        end
                    end else begin
                        id_next   = id_new;
                        size_next = size_new;
                        if (hc_inc < hdr_len) begin
                            hc_next = hc_inc;
                            if (tag_dec == 28'd0) begin
                                hc_next       = 4'd0;
                                phase_next    = PH_SEEK;
                                evt_push      = 1'b1;
                                evt.event_res = EV_END;
                                evt.tag_last  = 1'b1;
                            end
                        end else begin
                            hc_next        = 4'd0;
                            kind_next      = lookup_kind(id_new, short_hdr);
                            frame_rem_next = fs;
                            if (tag_dec == 28'd0) begin
                                phase_next    = PH_SEEK;
                                evt_push      = 1'b1;
                                evt.event_res = EV_END;
                                evt.tag_last  = 1'b1;
                            end else if (fs == 28'd0) begin
                                phase_next = PH_FRAMEHDR;
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    tag_rem_next   = tag_dec;
                    frame_rem_next = frame_dec;
                    if (tag_dec == 28'd0) begin
                        frame_rem_next = 28'd0;
                        phase_next     = PH_SEEK;
                    end else if (frame_dec == 28'd0) begin
                        phase_next = PH_FRAMEHDR;
                    end
                    evt_push        = 1'b1;
                    evt.event_res   = EV_DATA;
                    evt.frame_kind  = kind_reg;
                    evt.data_byte   = stream_byte;
                    evt.frame_last  = (frame_dec == 28'd0) || (tag_dec == 28'd0);
                    evt.tag_last    = (tag_dec == 28'd0);
                end
                PH_SKIP: begin
                    tag_rem_next = tag_dec;
                    if (tag_dec == 28'd0) begin
                        phase_next    = PH_SEEK;
                        evt_push      = 1'b1;
                        evt.event_res = EV_END;
                        evt.tag_last  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign evt_data = evt;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            hc_reg        <= 4'd0;
            id_reg        <= 32'd0;
            size_reg      <= 32'd0;
            ver_reg       <= 8'd0;
            tag_rem_reg   <= 28'd0;
            frame_rem_reg <= 28'd0;
            kind_reg      <= KIND_UNKNOWN;
        end else begin
            phase_reg     <= phase_next;
            hc_reg        <= hc_next;
            id_reg        <= id_next;
            size_reg      <= size_next;
            ver_reg       <= ver_next;
            tag_rem_reg   <= tag_rem_next;
            frame_rem_reg <= frame_rem_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

// ----- sv/id3d_queue.sv -----
module id3d_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  id3d_pkg::evt_t push_data,
    input  logic           pop,
    output id3d_pkg::evt_t pop_data,
    output logic           not_empty,
    output logic           not_full
);
    import id3d_pkg::*;

    localparam logic [QUEUE_CW-1:0] COUNT_FULL = QUEUE_CW'(QUEUE_DEPTH);
    localparam logic [QUEUE_AW-1:0] PTR_LAST   = QUEUE_AW'(QUEUE_DEPTH - 1);

    evt_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != COUNT_FULL);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

endmodule

// ----- sv/id3d_back.sv -----
module id3d_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  id3d_pkg::evt_t q_data,
    output logic           q_pop,
    input  logic           m_ready,
    output logic           m_valid,
    output id3d_pkg::evt_t m_data
);
    import id3d_pkg::*;

    logic valid_reg;
    evt_t data_reg;

    // refill the output register when empty or being taken
    assign q_pop   = q_not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

endmodule

// ----- sv/id3v2_frame_deframer_top.sv -----
// ID3v2 tag deframer. One file byte enters per transaction on the s_ channel, one
// per clock when the result side keeps up; s_stream_start restarts the parser on
// that byte. Each byte yields at most one result on the m_ channel: a payload byte
// with its frame kind and last marks, a tag header (version and decoded size), a
// tag end, or a no-tag event when the bytes where a tag may begin do not start one.
// A byte's result is registered on its way to m_valid: the parser classifies it
// in the accept cycle and writes a 4-entry result queue, and an output register
// presents it. s_ready falls only while that queue is full, so a stalled m_ready
// lets four more results be queued before input stalls. Bytes that yield no result
// stall too while the queue is full. max_tag_size lives at APB byte address 0; tags
// above it are skipped without frame parsing.
module id3v2_frame_deframer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input byte stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_stream_byte,
    input  logic                            s_stream_start,
    // result stream
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_event_res,
    output logic [3:0]                      m_frame_kind,
    output logic [7:0]                      m_data_byte,
    output logic                            m_frame_last,
    output logic                            m_tag_last,
    output logic [7:0]                      m_tag_version,
    output logic [27:0]                     m_tag_size,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [id3d_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import id3d_pkg::*;

    logic [27:0] max_tag_reg;
    logic        in_accept;
    logic        evt_push, q_not_empty, q_not_full, q_pop;
    evt_t        evt_in, q_data, out_data;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_TAG) ? {4'd0, max_tag_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tag_reg <= SIZE_MAX;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_TAG)) begin
            max_tag_reg <= pwdata[27:0];
        end
    end

    // input transaction
    assign s_ready   = q_not_full;
    assign in_accept = s_valid && s_ready;

    id3d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .stream_byte  (s_stream_byte),
        .stream_start (s_stream_start),
        .max_tag_size (max_tag_reg),
        .evt_push     (evt_push),
        .evt_data     (evt_in)
    );

    id3d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_data (evt_in),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    id3d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (out_data)
    );

    // result fields
    assign m_event_res   = out_data.event_res;
    assign m_frame_kind  = out_data.frame_kind;
    assign m_data_byte   = out_data.data_byte;
    assign m_frame_last  = out_data.frame_last;
    assign m_tag_last    = out_data.tag_last;
    assign m_tag_version = out_data.tag_version;
    assign m_tag_size    = out_data.tag_size;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import id3d_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_PRINTED   = 40;
    // byte address of max_tag_size
    localparam logic [PADDR_W-1:0] ADDR_MAX_TAG = '0;
    localparam logic [31:0] SYNCHSAFE_MASK = 32'h0FFF_FFFF;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_TAG_HDR,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_item_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // dut ports
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [7:0]          s_stream_byte  = 8'h00;
    logic                s_stream_start = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [1:0]          m_event_res;
    logic [3:0]          m_frame_kind;
    logic [7:0]          m_data_byte;
    logic                m_frame_last;
    logic                m_tag_last;
    logic [7:0]          m_tag_version;
    logic [27:0]         m_tag_size;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [31:0]         pwdata         = '0;
    logic [31:0]         prdata;
    logic                pready;

    id3v2_frame_deframer_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_stream_byte  (s_stream_byte),
        .s_stream_start (s_stream_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_frame_kind   (m_frame_kind),
        .m_data_byte    (m_data_byte),
        .m_frame_last   (m_frame_last),
        .m_tag_last     (m_tag_last),
        .m_tag_version  (m_tag_version),
        .m_tag_size     (m_tag_size),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // stimulus and scoreboard storage
    stream_item_t stream_queue[$];
    evt_t         expected_events[$];
    logic         next_start = 1'b0;
    int unsigned  n_queued   = 0;
    int unsigned  n_gen      = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_results  = 0;
    int unsigned  n_errors   = 0;
    int unsigned  n_settings = 0;
    int unsigned  cycle_count = 0;
    int unsigned  events_seen[4] = '{0, 0, 0, 0};

    // parser tracking state
    parse_phase_t parse_state;
    logic [3:0]   hdr_pos;
    logic [31:0]  id_acc;
    logic [31:0]  size_acc;
    logic [7:0]   tag_ver;
    logic [27:0]  tag_left;
    logic [31:0]  frame_left;
    logic [3:0]   cur_kind;
    logic [27:0]  tag_limit;

    // ------------------------------------------------------------------
    // expected behavior of the deframer
    // ------------------------------------------------------------------

    task automatic restart_parse();
        parse_state = PH_SEEK;
        hdr_pos     = '0;
        id_acc      = '0;
        size_acc    = '0;
        tag_ver     = '0;
        tag_left    = '0;
        frame_left  = '0;
        cur_kind    = KIND_UNKNOWN;
    endtask

    function automatic evt_t result_of(input event_t ev, input logic [3:0] kind,
                                       input logic [7:0] data, input logic fl,
                                       input logic tl, input logic [7:0] ver,
                                       input logic [27:0] size);
        evt_t r;
        r.event_res   = ev;
        r.frame_kind  = kind;
        r.data_byte   = data;
        r.frame_last  = fl;
        r.tag_last    = tl;
        r.tag_version = ver;
        r.tag_size    = size;
        return r;
    endfunction

    function automatic logic [3:0] frame_kind_of(input logic [31:0] id, input logic short_hdr);
        logic [3:0] k;
        k = KIND_UNKNOWN;
        if (short_hdr) begin
            case (id[23:0])
                "TT2": k = KIND_TIT2;
                "TP1": k = KIND_TPE1;
                "TAL": k = KIND_TALB;
                "COM": k = KIND_COMM;
                default: k = KIND_UNKNOWN;
            endcase
        end else begin
            case (id)
                "APIC": k = KIND_APIC;
                "COMM": k = KIND_COMM;
                "TALB": k = KIND_TALB;
                "TIT2": k = KIND_TIT2;
                "TPE1": k = KIND_TPE1;
                "TYER": k = KIND_TYER;
                "TCON": k = KIND_TCON;
                "TRCK": k = KIND_TRCK;
                "USLT": k = KIND_USLT;
                default: k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

    // one byte of a skipped tag body; tag end on its last byte
    task automatic skip_tag_byte(output logic hit, output evt_t ev);
        hit = 1'b0;
        ev  = '0;
        if (tag_left != 0) tag_left--;
        if (tag_left == 0) begin
            parse_state = PH_SEEK;
            hit = 1'b1;
            ev  = result_of(EV_END, KIND_UNKNOWN, 8'h00, 1'b0, 1'b1, 8'h00, '0);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic start,
                                output logic hit, output evt_t ev);
        logic        short_hdr;
        logic        room;
        logic        fl;
        logic        tl;
        logic [3:0]  hdr_len;
        logic [3:0]  id_len;
        logic [31:0] fsize;
        hit = 1'b0;
        ev  = '0;
        if (start) restart_parse();
        case (parse_state)
            PH_SEEK: begin
                if (b == CH_I) begin
                    parse_state = PH_TAG_HDR;
                    hdr_pos     = 4'd1;
                    size_acc    = '0;
                end else if (b != 8'h00) begin
                    parse_state = PH_DONE;
                    hit = 1'b1;
                    ev  = result_of(EV_NOTAG, KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, 8'h00, '0);
                end
            end
            PH_TAG_HDR: begin
                if ((hdr_pos == 4'd1 && b != CH_D) || (hdr_pos == 4'd2 && b != CH_3)) begin
                    parse_state = PH_DONE;
                    hit = 1'b1;
                    ev  = result_of(EV_NOTAG, KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, 8'h00, '0);
                end else begin
                    if (hdr_pos == TAG_HDR_VER) tag_ver = b;
                    // synchsafe size, bit 7 of each byte dropped
                    if (hdr_pos >= TAG_HDR_SIZE0)
                        size_acc = ((size_acc << 7) | {25'd0, b[6:0]}) & SYNCHSAFE_MASK;
                    if (hdr_pos < TAG_HDR_LAST) begin
                        hdr_pos++;
                    end else begin
                        hdr_pos  = '0;
                        tag_left = size_acc[27:0];
                        if (tag_left == 0)
                            parse_state = PH_SEEK;
                        else if (tag_left > tag_limit || tag_ver < VER_MIN || tag_ver > VER_MAX)
                            parse_state = PH_SKIP;
                        else
                            parse_state = PH_FRAME_HDR;
                        hit = 1'b1;
                        ev  = result_of(EV_TAG, KIND_UNKNOWN, 8'h00, 1'b0, tag_left == 0,
                                        tag_ver, tag_left);
                    end
                end
            end
            PH_FRAME_HDR: begin
                short_hdr = (tag_ver == VER_SHORT);
                hdr_len   = short_hdr ? HDR_LEN_SHORT : HDR_LEN_LONG;
                id_len    = short_hdr ? ID_LEN_SHORT : ID_LEN_LONG;
                room      = short_hdr ? (tag_left >= HDR_LEN_SHORT) : (tag_left > HDR_LEN_LONG);
                if (hdr_pos == 0 && (!room || b == 8'h00)) begin
                    // padding or no room for another frame
                    parse_state = PH_SKIP;
                    skip_tag_byte(hit, ev);
                end else begin
                    if (hdr_pos == 0) begin
                        id_acc   = '0;
                        size_acc = '0;
                    end
                    if (tag_left != 0) tag_left--;
                    if (hdr_pos < id_len)
                        id_acc = {id_acc[23:0], b};
                    else if (hdr_pos < 2 * id_len)
                        size_acc = {size_acc[23:0], b};
                    hdr_pos++;
                    if (hdr_pos < hdr_len) begin
                        // tag runs out inside the header
                        if (tag_left == 0) begin
                            hdr_pos     = '0;
                            parse_state = PH_SEEK;
                            hit = 1'b1;
                            ev  = result_of(EV_END, KIND_UNKNOWN, 8'h00, 1'b0, 1'b1, 8'h00, '0);
                        end
                    end else begin
                        hdr_pos  = '0;
                        cur_kind = frame_kind_of(id_acc, short_hdr);
                        fsize    = size_acc;
                        if (fsize > {4'd0, tag_left}) fsize = {4'd0, tag_left};
                        frame_left = fsize;
                        if (tag_left == 0) begin
                            parse_state = PH_SEEK;
                            hit = 1'b1;
                            ev  = result_of(EV_END, KIND_UNKNOWN, 8'h00, 1'b0, 1'b1, 8'h00, '0);
                        end else begin
                            parse_state = (fsize == 0) ? PH_FRAME_HDR : PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (tag_left != 0) tag_left--;
                if (frame_left != 0) frame_left--;
                tl = (tag_left == 0);
                fl = (frame_left == 0) || tl;
                if (tl) begin
                    frame_left  = '0;
                    parse_state = PH_SEEK;
                end else if (fl) begin
                    parse_state = PH_FRAME_HDR;
                end
                hit = 1'b1;
                ev  = result_of(EV_DATA, cur_kind, b, fl, tl, 8'h00, '0);
            end
            PH_SKIP: skip_tag_byte(hit, ev);
            default: hit = 1'b0;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b, input bit counted = 1'b1);
        stream_item_t it;
        it.data  = b;
        it.start = next_start;
        stream_queue.push_back(it);
        next_start = 1'b0;
        n_queued++;
        if (counted) n_gen++;
    endtask

    // tag header plus a body of frames (random bytes for a bad version), optionally cut off early
    task automatic push_tag(input logic [7:0] ver, input int unsigned size, input bit cut_short);
        logic [7:0]  body[$];
        logic [31:0] fid;
        logic [31:0] fsize;
        logic [31:0] sz_bits;
        logic        short_hdr;
        int unsigned plen;
        int unsigned keep;
        int unsigned pick;
        int          k;
        short_hdr = (ver == VER_SHORT);
        put_byte(CH_I);
        put_byte(CH_D);
        put_byte(CH_3);
        put_byte(ver);
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
        for (k = 3; k >= 0; k--) begin
            sz_bits = size >> (7 * k);
            put_byte({$urandom_range(0, 5) == 0, sz_bits[6:0]});
        end
        if (ver < VER_MIN || ver > VER_MAX) begin
            while (body.size() < size) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            while (body.size() < size) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // padding to the end of the tag
                    while (body.size() < size) body.push_back(8'h00);
                end else begin
                    if (short_hdr) begin
                        case ($urandom_range(0, 5))
                            0: fid = {8'd0, "TT2"};
                            1: fid = {8'd0, "TP1"};
                            2: fid = {8'd0, "TAL"};
                            3: fid = {8'd0, "COM"};
                            4: fid = {8'd0, "TYE"};
                            default: fid = $urandom;
                        endcase
                    end else begin
                        case ($urandom_range(0, 10))
                            0: fid = "APIC";
                            1: fid = "COMM";
                            2: fid = "TALB";
                            3: fid = "TIT2";
                            4: fid = "TPE1";
                            5: fid = "TYER";
                            6: fid = "TCON";
                            7: fid = "TRCK";
                            8: fid = "USLT";
                            9: fid = "TT2 ";
                            default: fid = $urandom;
                        endcase
                    end
                    if (pick == 1)
                        fsize = $urandom;
                    else if (pick == 2)
                        fsize = '0;
                    else
                        fsize = $urandom_range(1, 12);
                    if (short_hdr) begin
                        fsize = fsize & 32'h00FF_FFFF;
                        body.push_back(fid[23:16]);
                        body.push_back(fid[15:8]);
                        body.push_back(fid[7:0]);
                        body.push_back(fsize[23:16]);
                        body.push_back(fsize[15:8]);
                        body.push_back(fsize[7:0]);
                    end else begin
                        body.push_back(fid[31:24]);
                        body.push_back(fid[23:16]);
                        body.push_back(fid[15:8]);
                        body.push_back(fid[7:0]);
                        body.push_back(fsize[31:24]);
                        body.push_back(fsize[23:16]);
                        body.push_back(fsize[15:8]);
                        body.push_back(fsize[7:0]);
                        body.push_back(8'($urandom_range(0, 255)));
                        body.push_back(8'($urandom_range(0, 255)));
                    end
                    plen = (fsize > size) ? size : fsize;
                    repeat (plen) body.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        keep = cut_short ? $urandom_range(0, size) : size;
        for (k = 0; k < keep; k++) put_byte(body[k]);
    endtask

    // one file: leading zeros, chained tags, then audio or a broken magic, unless a tag is cut off
    task automatic push_file();
        int unsigned n_tags;
        int unsigned size;
        int unsigned t;
        int unsigned r;
        logic [7:0]  ver;
        logic [7:0]  b;
        next_start = 1'b1;
        repeat ($urandom_range(0, 2)) put_byte(8'h00);
        n_tags = $urandom_range(1, 3);
        for (t = 0; t < n_tags; t++) begin
            r = $urandom_range(0, 19);
            if (r < 8)
                ver = 8'd3;
            else if (r < 13)
                ver = 8'd4;
            else if (r < 18)
                ver = VER_SHORT;
            else if (r == 18)
                ver = 8'($urandom_range(0, 1));
            else
                ver = 8'($urandom_range(5, 255));
            r = $urandom_range(0, 19);
            if (r == 0)
                size = 0;
            else if (r < 15)
                size = $urandom_range(1, 40);
            else
                size = $urandom_range(41, 110);
            // a new file may cut into the middle of a tag
            if ($urandom_range(0, 19) == 0) begin
                push_tag(ver, size, 1'b1);
                return;
            end
            push_tag(ver, size, 1'b0);
            if ($urandom_range(0, 3) == 0) put_byte(8'h00);
        end
        case ($urandom_range(0, 3))
            0: put_byte(8'hFF);
            1: begin
                put_byte(CH_I);
                put_byte($urandom_range(0, 1) ? 8'h58 : 8'h00);
            end
            2: begin
                put_byte(CH_I);
                put_byte(CH_D);
                put_byte(8'h34);
            end
            default: begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_I) b = 8'h4A;
                put_byte(b);
            end
        endcase
        // bytes after parsing stopped are ignored
        repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic push_files(input int unsigned n_items);
        int unsigned target;
        target = n_gen + n_items;
        while (n_gen < target) push_file();
    endtask

    // ------------------------------------------------------------------
    // configuration and phase control
    // ------------------------------------------------------------------

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_TAG) tag_limit = data[27:0];
        n_settings++;
    endtask

    // wait until every byte is taken and every result seen
    task automatic wait_idle();
        int unsigned n;
        n = 0;
        while ((n_accepted != n_queued || expected_events.size() != 0) && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $time, n_results, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of transactions with random gaps
    // ------------------------------------------------------------------

    stream_item_t tx_item;
    int unsigned  burst_left = 0;
    int unsigned  gap_left   = 0;
    logic         tx_hit;
    evt_t         tx_evt;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // accepted transaction goes through the parser tracker
            if (s_valid && s_ready) begin
                deframe_byte(s_stream_byte, s_stream_start, tx_hit, tx_evt);
                if (tx_hit) expected_events.push_back(tx_evt);
                n_accepted++;
            end
            // next transaction once the current one is gone
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stream_queue.size() != 0) begin
                    tx_item = stream_queue.pop_front();
                    s_valid        <= 1'b1;
                    s_stream_byte  <= tx_item.data;
                    s_stream_start <= tx_item.start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern, long hold-offs and result checking
    // ------------------------------------------------------------------

    evt_t        rx_want;
    int unsigned rx_cycle   = 0;
    int unsigned hold_left  = 0;
    logic [31:0] ready_mask = '1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                events_seen[m_event_res]++;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected result, event_res", 32'(m_event_res), '0);
                end else begin
                    rx_want = expected_events.pop_front();
                    if (m_event_res !== rx_want.event_res)
                        report_mismatch("event_res", 32'(m_event_res),
                                        32'(rx_want.event_res));
                    if (m_frame_kind !== rx_want.frame_kind)
                        report_mismatch("frame_kind", 32'(m_frame_kind),
                                        32'(rx_want.frame_kind));
                    if (m_data_byte !== rx_want.data_byte)
                        report_mismatch("data_byte", 32'(m_data_byte),
                                        32'(rx_want.data_byte));
                    if (m_frame_last !== rx_want.frame_last)
                        report_mismatch("frame_last", 32'(m_frame_last),
                                        32'(rx_want.frame_last));
                    if (m_tag_last !== rx_want.tag_last)
                        report_mismatch("tag_last", 32'(m_tag_last),
                                        32'(rx_want.tag_last));
                    if (m_tag_version !== rx_want.tag_version)
                        report_mismatch("tag_version", 32'(m_tag_version),
                                        32'(rx_want.tag_version));
                    if (m_tag_size !== rx_want.tag_size)
                        report_mismatch("tag_size", 32'(m_tag_size),
                                        32'(rx_want.tag_size));
                end
                // long hold-off so the result queue fills and input stalls
                if (n_results == 80 || n_results == 400 || n_results == 800)
                    hold_left = 150;
            end
            rx_cycle++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_cycle[5:0] == 6'd0) begin
                    case ($urandom_range(0, 3))
                        0: ready_mask = '1;
                        1: ready_mask = $urandom | $urandom;
                        2: ready_mask = $urandom;
                        default: ready_mask = $urandom & $urandom;
                    endcase
                end
                m_ready <= ready_mask[rx_cycle[4:0]];
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_events.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        restart_parse();
        tag_limit = SIZE_MAX;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: huge tag with odd version, bad magic, no tag, empty tag
        apb_write(ADDR_MAX_TAG, {4'h0, SIZE_MAX});
        next_start = 1'b1;
        put_byte(CH_I); put_byte(CH_D); put_byte(CH_3); put_byte(8'hFF);
        put_byte(8'h00); put_byte(8'hFF);
        put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
        next_start = 1'b1;
        put_byte(CH_I); put_byte(8'h58);
        next_start = 1'b1;
        put_byte(8'h00); put_byte(8'h4D); put_byte(8'h51, 1'b0);
        next_start = 1'b1;
        put_byte(CH_I); put_byte(CH_D); put_byte(CH_3); put_byte(8'h04);
        put_byte(8'h00); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
        wait_idle();

        // every nonempty tag skipped
        apb_write(ADDR_MAX_TAG, 32'h0000_0000);
        push_files(250);
        wait_idle();

        // mix of parsed and skipped tags
        apb_write(ADDR_MAX_TAG, 32'd40);
        push_files(450);
        wait_idle();

        // every tag with a valid version parsed, with a full drain in the middle
        apb_write(ADDR_MAX_TAG, {4'h0, SIZE_MAX});
        push_files(400);
        wait_idle();
        push_files(350);
        wait_idle();

        // upper data bits ignored, only one-byte tags parsed
        apb_write(ADDR_MAX_TAG, 32'hF000_0001);
        push_files(200);
        wait_idle();

        if (expected_events.size() != 0)
            report_mismatch("results never seen, count", expected_events.size(), '0);
        $display("stream of %0d bytes over %0d max_tag_size settings in %0d cycles",
                 n_accepted, n_settings, cycle_count);
        $display("results: %0d payload, %0d tag header, %0d tag end, %0d no-tag, %0d mismatches",
                 events_seen[EV_DATA], events_seen[EV_TAG], events_seen[EV_END],
                 events_seen[EV_NOTAG], n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/id3d_pkg.sv
sv/id3d_front.sv
sv/id3d_queue.sv
sv/id3d_back.sv
sv/id3v2_frame_deframer_top.sv
verif/tb_top.sv
